FILE: hdl/tosm_pkg.sv
// Package for the transaction output script matcher.
// Holds parser phases, result kinds, register indexes and byte constants.
// No dependencies.
package tosm_pkg;

    // Parser phases: one per field of the serialized transaction, plus done and error.
    typedef enum logic [3:0] {
        PH_VER        = 4'd0,
        PH_MARK       = 4'd1,
        PH_FLAG       = 4'd2,
        PH_INCNT      = 4'd3,
        PH_IN_OUTPT   = 4'd4,
        PH_IN_SLEN    = 4'd5,
        PH_IN_SCRIPT  = 4'd6,
        PH_IN_SEQ     = 4'd7,
        PH_OUTCNT     = 4'd8,
        PH_OUT_AMT    = 4'd9,
        PH_OUT_SLEN   = 4'd10,
        PH_OUT_SCRIPT = 4'd11,
        PH_DONE       = 4'd12,
        PH_ERR        = 4'd13
    } t_phase;

    // Result kinds carried on the output channel.
    typedef enum logic [1:0] {
        KIND_MATCH     = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_NOT_FOUND = 2'd2,
        KIND_MALFORMED = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TARGET_LENGTH = 3'd0;
    localparam logic [2:0] CFG_TARGET_WORD0  = 3'd1;
    localparam logic [2:0] CFG_TARGET_WORD1  = 3'd2;
    localparam logic [2:0] CFG_TARGET_WORD2  = 3'd3;
    localparam logic [2:0] CFG_TARGET_WORD3  = 3'd4;
    localparam logic [2:0] CFG_TARGET_WORD4  = 3'd5;
    localparam logic [2:0] CFG_TARGET_WORD5  = 3'd6;

    localparam int unsigned TARGET_WORDS     = 6;
    localparam int unsigned TARGET_BITS      = TARGET_WORDS * 64;
    localparam logic [5:0]  MAX_TARGET_BYTES = 6'd48;

    // Field sizes in bytes.
    localparam logic [5:0] VERSION_BYTES  = 6'd4;
    localparam logic [5:0] OUTPOINT_BYTES = 6'd36;
    localparam logic [5:0] SEQUENCE_BYTES = 6'd4;
    localparam logic [5:0] AMOUNT_BYTES   = 6'd8;

    // Special byte values.
    localparam logic [7:0] VARINT_PFX16 = 8'hfd;
    localparam logic [7:0] VARINT_PFX32 = 8'hfe;
    localparam logic [7:0] MARKER_BYTE  = 8'h00;
    localparam logic [7:0] FLAG_BYTE    = 8'h01;

    // Results caused by one accepted byte: an optional match, then an
    // optional verdict.
    typedef struct packed {
        logic        has_match;
        logic [31:0] index;
        logic [63:0] amount;
        logic        has_end;
        t_kind       verdict;
    } t_res_pair;

endpackage

FILE: hdl/tosm_in_if.sv
// Input channel of the transaction output script matcher: one byte per transfer.
// Depends on nothing.
interface tosm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_tx;

    modport source (output valid, output data_byte, output end_of_tx, input ready);
    modport sink   (input valid, input data_byte, input end_of_tx, output ready);
endinterface

FILE: hdl/tosm_out_if.sv
// Output channel of the transaction output script matcher: one result per transfer.
// Depends on nothing.
interface tosm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] output_index;
    logic [63:0] amount;
    logic        final_res;

    modport source (output valid, output kind, output output_index, output amount,
                    output final_res, input ready);
    modport sink   (input valid, input kind, input output_index, input amount,
                    input final_res, output ready);
endinterface

FILE: hdl/tx_output_script_matcher_top.sv
// Top level of the transaction output script matcher.
// Depends on tosm_pkg, tosm_in_if and tosm_out_if.
//
// Usage:
//   i_in carries the serialized transaction, one byte per transfer, with
//   end_of_tx set on its final byte. o_out carries results: a match (kind
//   KIND_MATCH with the output index and amount) for every output whose
//   script equals the target, and on the final byte a verdict (found, not
//   found or malformed). final_res marks the last result caused by a byte. The user
//   must load the target script through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle, which it does not enforce. It is kept across transactions.
// Timing:
//   Each accepted byte updates the parser state in the same cycle and its
//   results are written into a two-entry result queue; a result is visible
//   on o_out when its entry is at the head of the queue. One byte per cycle is
//   accepted as long as the queue has room; a byte with a match and a
//   verdict sends two results, match first. The queue size sets how far the input
//   runs ahead of a stalled receiver: with two bytes' results waiting,
//   i_in.ready drops until o_out takes the last result of one of them.
// Reset:
//   i_rst_n (synchronous, active low) clears the parser, the queue and the
//   target registers; the block then expects the version of a new stream.
module tx_output_script_matcher_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    tosm_in_if.sink           i_in,
    tosm_out_if.source        o_out
);

    // ---------------------------------------------------------------- config
    logic [5:0]                       r_target_len;
    logic [tosm_pkg::TARGET_BITS-1:0] r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_len <= '0;
            r_target     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tosm_pkg::CFG_TARGET_LENGTH: r_target_len       <= i_cfg_data[5:0];
                tosm_pkg::CFG_TARGET_WORD0:  r_target[0*64 +: 64] <= i_cfg_data;
                tosm_pkg::CFG_TARGET_WORD1:  r_target[1*64 +: 64] <= i_cfg_data;
                tosm_pkg::CFG_TARGET_WORD2:  r_target[2*64 +: 64] <= i_cfg_data;
                tosm_pkg::CFG_TARGET_WORD3:  r_target[3*64 +: 64] <= i_cfg_data;
                tosm_pkg::CFG_TARGET_WORD4:  r_target[4*64 +: 64] <= i_cfg_data;
                tosm_pkg::CFG_TARGET_WORD5:  r_target[5*64 +: 64] <= i_cfg_data;
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // ---------------------------------------------------------- parser state
    tosm_pkg::t_phase r_phase,        n_phase;
    logic [5:0]       r_field_count,  n_field_count;
    logic [63:0]      r_varint_accum, n_varint_accum;
    logic [3:0]       r_varint_left,  n_varint_left;
    logic [31:0]      r_inputs_left,  n_inputs_left;
    logic [31:0]      r_outputs_left, n_outputs_left;
    logic [31:0]      r_out_index,    n_out_index;
    logic [63:0]      r_out_amount,   n_out_amount;
    logic [31:0]      r_script_left,  n_script_left;
    logic [5:0]       r_script_pos,   n_script_pos;
    logic             r_match,        n_match;
    logic             r_any_found,    n_any_found;
    logic             r_segwit,       n_segwit;

    logic             in_fire;
    logic             fin_emit;

    // Result queue: two entries, each holding the results of one byte.
    tosm_pkg::t_res_pair r_q [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_cnt;
    logic                r_sub;
    tosm_pkg::t_res_pair head;
    tosm_pkg::t_res_pair res_pair;
    logic                push;
    logic                pop;
    logic                out_fire;

    assign i_in.ready = (r_cnt != 2'd2);
    assign in_fire    = i_in.valid && i_in.ready;

    // ORs a byte into the lane of a 64-bit word picked by the low bits of the field counter.
    function automatic logic [63:0] lane_or(input logic [63:0] word, input logic [2:0] lane,
                                            input logic [7:0] b);
        logic [63:0] res;
        res = word;
        for (int k = 0; k < 8; k++) begin
            if (lane == 3'(k)) begin
                res[k*8 +: 8] = word[k*8 +: 8] | b;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------ next state of the parser
    logic [7:0]  b;
    logic [3:0]  vl_in;
    logic [5:0]  fc_inc;
    logic        vf_done;
    logic [63:0] vf_val;
    logic [3:0]  vf_left;
    logic [63:0] vf_acc;
    logic [5:0]  vf_fc;
    logic [31:0] vf_sat;
    logic [31:0] sl_dec;
    logic [31:0] il_dec;
    logic [31:0] ol_dec;
    logic [7:0]  tbyte;
    logic        do_incnt;
    logic        fin;

    always_comb begin
        b      = i_in.data_byte;
        // the marker byte doubles as the first byte of the input count
        vl_in  = (r_phase == tosm_pkg::PH_MARK) ? 4'd0 : r_varint_left;
        fc_inc = r_field_count + 6'd1;
        sl_dec = r_script_left - 32'd1;
        il_dec = r_inputs_left - 32'd1;
        ol_dec = r_outputs_left - 32'd1;

        // varint decoder
        if (vl_in == 4'd0) begin
            vf_acc = r_varint_accum;
            vf_fc  = r_field_count;
            if (b < tosm_pkg::VARINT_PFX16) begin
                vf_done = 1'b1;
                vf_val  = {56'd0, b};
                vf_left = 4'd0;
            end else begin
                vf_done = 1'b0;
                vf_val  = '0;
                vf_acc  = '0;
                vf_fc   = '0;
                vf_left = (b == tosm_pkg::VARINT_PFX16) ? 4'd2 :
                          (b == tosm_pkg::VARINT_PFX32) ? 4'd4 : 4'd8;
            end
        end else begin
            vf_acc  = lane_or(r_varint_accum, r_field_count[2:0], b);
            vf_fc   = fc_inc;
            vf_left = vl_in - 4'd1;
            vf_done = (vf_left == 4'd0);
            vf_val  = vf_acc;
        end
        vf_sat = (|vf_val[63:32]) ? 32'hFFFF_FFFF : vf_val[31:0];

        if (r_script_pos < tosm_pkg::MAX_TARGET_BYTES) begin
            tbyte = r_target[{r_script_pos, 3'b000} +: 8];
        end else begin
            tbyte = 8'd0;
        end

        n_phase        = r_phase;
        n_field_count  = r_field_count;
        n_varint_accum = r_varint_accum;
        n_varint_left  = r_varint_left;
        n_inputs_left  = r_inputs_left;
        n_outputs_left = r_outputs_left;
        n_out_index    = r_out_index;
        n_out_amount   = r_out_amount;
        n_script_left  = r_script_left;
        n_script_pos   = r_script_pos;
        n_match        = r_match;
        n_any_found    = r_any_found;
        n_segwit       = r_segwit;
        do_incnt       = 1'b0;
        fin            = 1'b0;

        unique case (r_phase)
            tosm_pkg::PH_VER: begin
                n_field_count = fc_inc;
                if (fc_inc >= tosm_pkg::VERSION_BYTES) begin
                    n_field_count = '0;
                    n_phase       = tosm_pkg::PH_MARK;
                end
            end
            tosm_pkg::PH_MARK: begin
                n_varint_left = '0;
                if (b == tosm_pkg::MARKER_BYTE) begin
                    n_phase = tosm_pkg::PH_FLAG;
                end else begin
                    n_phase  = tosm_pkg::PH_INCNT;
                    do_incnt = 1'b1;
                end
            end
            tosm_pkg::PH_FLAG: begin
                if (b == tosm_pkg::FLAG_BYTE) begin
                    n_segwit      = 1'b1;
                    n_varint_left = '0;
                    n_phase       = tosm_pkg::PH_INCNT;
                end else begin
                    n_phase = tosm_pkg::PH_ERR;
                end
            end
            tosm_pkg::PH_INCNT: begin
                do_incnt = 1'b1;
            end
            tosm_pkg::PH_IN_OUTPT: begin
                n_field_count = fc_inc;
                if (fc_inc >= tosm_pkg::OUTPOINT_BYTES) begin
                    n_field_count = '0;
                    n_varint_left = '0;
                    n_phase       = tosm_pkg::PH_IN_SLEN;
                end
            end
            tosm_pkg::PH_IN_SLEN: begin
                n_varint_left  = vf_left;
                n_varint_accum = vf_acc;
                n_field_count  = vf_fc;
                if (vf_done) begin
                    n_script_left = vf_sat;
                    n_field_count = '0;
                    n_phase       = (vf_sat == 32'd0) ? tosm_pkg::PH_IN_SEQ
                                                      : tosm_pkg::PH_IN_SCRIPT;
                end
            end
            tosm_pkg::PH_IN_SCRIPT: begin
                n_script_left = sl_dec;
                if (sl_dec == 32'd0) begin
                    n_field_count = '0;
                    n_phase       = tosm_pkg::PH_IN_SEQ;
                end
            end
            tosm_pkg::PH_IN_SEQ: begin
                n_field_count = fc_inc;
                if (fc_inc >= tosm_pkg::SEQUENCE_BYTES) begin
                    n_field_count = '0;
                    n_inputs_left = il_dec;
                    n_varint_left = '0;
                    n_phase       = (il_dec == 32'd0) ? tosm_pkg::PH_OUTCNT
                                                      : tosm_pkg::PH_IN_OUTPT;
                end
            end
            tosm_pkg::PH_OUTCNT: begin
                n_varint_left  = vf_left;
                n_varint_accum = vf_acc;
                n_field_count  = vf_fc;
                if (vf_done) begin
                    if (vf_val == 64'd0) begin
                        n_phase = tosm_pkg::PH_DONE;
                    end else begin
                        n_outputs_left = vf_sat;
                        n_out_index    = '0;
                        n_field_count  = '0;
                        n_phase        = tosm_pkg::PH_OUT_AMT;
                    end
                end
            end
            tosm_pkg::PH_OUT_AMT: begin
                n_out_amount  = lane_or((r_field_count == 6'd0) ? 64'd0 : r_out_amount,
                                        r_field_count[2:0], b);
                n_field_count = fc_inc;
                if (fc_inc >= tosm_pkg::AMOUNT_BYTES) begin
                    n_field_count = '0;
                    n_varint_left = '0;
                    n_phase       = tosm_pkg::PH_OUT_SLEN;
                end
            end
            tosm_pkg::PH_OUT_SLEN: begin
                n_varint_left  = vf_left;
                n_varint_accum = vf_acc;
                n_field_count  = vf_fc;
                if (vf_done) begin
                    n_script_left = vf_sat;
                    n_script_pos  = '0;
                    n_match       = (r_target_len != 6'd0)
                                 && (r_target_len <= tosm_pkg::MAX_TARGET_BYTES)
                                 && (vf_val == {58'd0, r_target_len});
                    if (vf_sat == 32'd0) begin
                        fin = 1'b1;
                    end else begin
                        n_phase = tosm_pkg::PH_OUT_SCRIPT;
                    end
                end
            end
            tosm_pkg::PH_OUT_SCRIPT: begin
                if (r_match) begin
                    if (b != tbyte) begin
                        n_match = 1'b0;
                    end
                    n_script_pos = r_script_pos + 6'd1;
                end
                n_script_left = sl_dec;
                if (sl_dec == 32'd0) begin
                    fin = 1'b1;
                end
            end
            default: begin
                // done and error phases ignore bytes
            end
        endcase

        // input count varint
        if (do_incnt) begin
            n_varint_left  = vf_left;
            n_varint_accum = vf_acc;
            n_field_count  = vf_fc;
            if (vf_done) begin
                if (vf_val == 64'd0) begin
                    n_phase       = r_segwit ? tosm_pkg::PH_OUTCNT : tosm_pkg::PH_ERR;
                    n_varint_left = '0;
                end else begin
                    n_inputs_left = vf_sat;
                    n_field_count = '0;
                    n_phase       = tosm_pkg::PH_IN_OUTPT;
                end
            end
        end

        // end of an output script: report a match and advance to the next output or to done
        fin_emit = fin && n_match;
        if (fin) begin
            if (n_match) begin
                n_any_found = 1'b1;
            end
            n_match        = 1'b0;
            n_out_index    = r_out_index + 32'd1;
            n_outputs_left = ol_dec;
            n_field_count  = '0;
            n_phase        = (ol_dec == 32'd0) ? tosm_pkg::PH_DONE : tosm_pkg::PH_OUT_AMT;
        end
    end

    // --------------------------------------------- results caused by this byte
    tosm_pkg::t_kind done_kind;

    always_comb begin
        done_kind = n_any_found ? tosm_pkg::KIND_FOUND : tosm_pkg::KIND_NOT_FOUND;

        res_pair.has_match = fin_emit;
        res_pair.index     = r_out_index;
        res_pair.amount    = r_out_amount;
        res_pair.has_end   = i_in.end_of_tx;

        unique case (n_phase)
            tosm_pkg::PH_DONE, tosm_pkg::PH_OUTCNT: begin
                res_pair.verdict = done_kind;
            end
            tosm_pkg::PH_INCNT: begin
                res_pair.verdict = (n_segwit && n_varint_left == 4'd0)
                                 ? tosm_pkg::KIND_NOT_FOUND : tosm_pkg::KIND_MALFORMED;
            end
            tosm_pkg::PH_OUT_SLEN: begin
                res_pair.verdict = (n_varint_left == 4'd0 && n_outputs_left == 32'd1)
                                 ? done_kind : tosm_pkg::KIND_MALFORMED;
            end
            default: begin
                res_pair.verdict = tosm_pkg::KIND_MALFORMED;
            end
        endcase

        push = in_fire && (fin_emit || i_in.end_of_tx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_fire && i_in.end_of_tx)) begin
            // reset or end of transaction: return to the version phase, keep the target
            r_phase        <= tosm_pkg::PH_VER;
            r_field_count  <= '0;
            r_varint_accum <= '0;
            r_varint_left  <= '0;
            r_inputs_left  <= '0;
            r_outputs_left <= '0;
            r_out_index    <= '0;
            r_out_amount   <= '0;
            r_script_left  <= '0;
            r_script_pos   <= '0;
            r_match        <= 1'b0;
            r_any_found    <= 1'b0;
            r_segwit       <= 1'b0;
        end else if (in_fire) begin
            r_phase        <= n_phase;
            r_field_count  <= n_field_count;
            r_varint_accum <= n_varint_accum;
            r_varint_left  <= n_varint_left;
            r_inputs_left  <= n_inputs_left;
            r_outputs_left <= n_outputs_left;
            r_out_index    <= n_out_index;
            r_out_amount   <= n_out_amount;
            r_script_left  <= n_script_left;
            r_script_pos   <= n_script_pos;
            r_match        <= n_match;
            r_any_found    <= n_any_found;
            r_segwit       <= n_segwit;
        end
    end

    // ----------------------------------------------------------- result queue
    assign head     = r_q[r_rd_ptr];
    assign out_fire = o_out.valid && o_out.ready;
    // hold the entry while its match goes out ahead of its verdict
    assign pop      = out_fire && !(head.has_match && head.has_end && !r_sub);

    always_comb begin
        o_out.valid = (r_cnt != 2'd0);
        if (head.has_match && !r_sub) begin
            o_out.kind         = tosm_pkg::KIND_MATCH;
            o_out.output_index = head.index;
            o_out.amount       = head.amount;
            o_out.final_res    = !head.has_end;
        end else begin
            o_out.kind         = head.verdict;
            o_out.output_index = '0;
            o_out.amount       = '0;
            o_out.final_res    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= res_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (out_fire) begin
                r_sub    <= 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // ------------------------------------------------------------- assertions
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result queue overfilled");

    a_sub_only_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (r_cnt != 2'd0 && head.has_match && head.has_end))
        else $error("split flag set on an entry without two results");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (head.has_match || head.has_end))
        else $error("empty entry at queue head");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.end_of_tx) |=> (r_phase == tosm_pkg::PH_VER && !r_any_found))
        else $error("parser not cleared after end of transaction");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_script_pos <= tosm_pkg::MAX_TARGET_BYTES)
        else $error("script compare position beyond target");

endmodule
